// File: rtl/hse_pkg.sv
// Shared types and constants of the heap sort engine.
`default_nettype none
package hse_pkg;

  localparam int VALUE_W             = 64;
  localparam int DEFAULT_STORE_DEPTH = 64;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_INIT,
    OP_RD_NODE,
    OP_LD_NODE,
    OP_RD_RIGHT,
    OP_CMP,
    OP_FIN,
    OP_NEXT_BUILD,
    OP_X_RD_ROOT,
    OP_X_RD_LAST,
    OP_X_SWAP,
    OP_OUT_RD,
    OP_OUT_CAP
  } dp_op_e;

  // Status flags the controller branches on.
  typedef struct packed {
    logic left_ok;       // left child of the current node lies in the heap
    logic cmp_move;      // a child beats the carried value
    logic next_left_ok;  // left child of the winning child lies in the heap
    logic build_zero;    // heap build has reached the root
    logic size_gt1;      // more than one entry left in the heap
    logic x_left_ok;     // after the swap, node 1 still lies in the heap
    logic out_free;      // output register can take an item
    logic out_last;      // the item being read out ends the batch
  } status_t;

endpackage
`default_nettype wire

// File: rtl/hse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hse_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/hse_datapath.sv
// Datapath of the heap sort engine: value store, sift registers and output register.
`default_nettype none
module hse_datapath #(
  parameter int STORE_DEPTH = hse_pkg::DEFAULT_STORE_DEPTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire hse_pkg::dp_op_e             op_i,
  output hse_pkg::status_t                 status_o,
  input  wire logic [hse_pkg::VALUE_W-1:0] s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  output logic      [hse_pkg::VALUE_W-1:0] m_axis_tdata_o,
  output logic                             m_axis_tlast_o,
  output logic      [0:0]                  m_axis_tuser_o
);
  import hse_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int IW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      size_q, size_d;
  logic               dropped_q, dropped_d;
  logic [AW-1:0]      p_q, p_d;
  logic [AW-1:0]      build_q, build_d;
  logic [AW-1:0]      k_q, k_d;
  logic               rvalid_q, rvalid_d;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] v_q, v_d;
  logic [VALUE_W-1:0] l_q, l_d;
  logic [VALUE_W-1:0] out_data_q, out_data_d;
  logic               out_last_q, out_last_d;
  logic               out_ovf_q, out_ovf_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic [IW-1:0]      left_p, right_p, size_x;
  logic               l_gt, r_gt;
  logic [IW-1:0]      top1, top;
  logic [VALUE_W-1:0] topval1, topval;
  logic [AW-1:0]      top_a;
  logic [IW-1:0]      left_top;
  logic               last_k;

  hse_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sift compare: the carried value against the left child, then the right child.
  // In the compare cycle the right child sits on the RAM read port.
  always_comb begin
    left_p   = IW'({p_q, 1'b1});
    right_p  = left_p + IW'(1);
    size_x   = IW'(size_q);
    l_gt     = $signed(v_q) < $signed(l_q);
    topval1  = l_gt ? l_q : v_q;
    top1     = l_gt ? left_p : IW'(p_q);
    r_gt     = rvalid_q && ($signed(topval1) < $signed(ram_rdata));
    top      = r_gt ? right_p : top1;
    topval   = r_gt ? ram_rdata : topval1;
    top_a    = top[AW-1:0];
    left_top = IW'({top_a, 1'b1});
    last_k   = (CW'(k_q) + CW'(1)) == count_q;
  end

  always_comb begin
    status_o.left_ok      = left_p < size_x;
    status_o.cmp_move     = l_gt || r_gt;
    status_o.next_left_ok = left_top < size_x;
    status_o.build_zero   = build_q == '0;
    status_o.size_gt1     = size_q > CW'(1);
    status_o.x_left_ok    = size_q > CW'(2);
    status_o.out_free     = !out_valid_q || m_axis_tready_i;
    status_o.out_last     = last_k;
  end

  always_comb begin
    count_d     = count_q;
    size_d      = size_q;
    dropped_d   = dropped_q;
    p_d         = p_q;
    build_d     = build_q;
    k_d         = k_q;
    rvalid_d    = rvalid_q;
    v_d         = v_q;
    l_d         = l_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = p_q;
    ram_wdata   = v_q;
    ram_raddr   = p_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (op_i)
      OP_IDLE: begin
      end
      OP_LOAD: begin
        if (count_q < DEPTH_C) begin
          ram_we    = 1'b1;
          ram_waddr = count_q[AW-1:0];
          ram_wdata = s_axis_tdata_i;
          count_d   = count_q + CW'(1);
        end else begin
          dropped_d = 1'b1;
        end
      end
      OP_INIT: begin
        size_d  = count_q;
        p_d     = AW'(count_q >> 1);
        build_d = AW'(count_q >> 1);
        k_d     = '0;
      end
      OP_RD_NODE: begin
        ram_raddr = p_q;
      end
      OP_LD_NODE: begin
        v_d       = ram_rdata;
        ram_raddr = left_p[AW-1:0];
      end
      OP_RD_RIGHT: begin
        l_d       = ram_rdata;
        ram_raddr = right_p[AW-1:0];
        rvalid_d  = right_p < size_x;
      end
      OP_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = p_q;
        if (l_gt || r_gt) begin
          // The winning child moves up; the hole follows it down.
          ram_wdata = topval;
          p_d       = top_a;
          ram_raddr = left_top[AW-1:0];
        end else begin
          ram_wdata = v_q;
        end
      end
      OP_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = p_q;
        ram_wdata = v_q;
      end
      OP_NEXT_BUILD: begin
        build_d = build_q - AW'(1);
        p_d     = build_q - AW'(1);
      end
      OP_X_RD_ROOT: begin
        ram_raddr = '0;
      end
      OP_X_RD_LAST: begin
        l_d       = ram_rdata;
        ram_raddr = AW'(size_q - CW'(1));
      end
      OP_X_SWAP: begin
        // The old root goes to the end; the last entry is carried down from the root.
        v_d       = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = AW'(size_q - CW'(1));
        ram_wdata = l_q;
        size_d    = size_q - CW'(1);
        p_d       = '0;
        ram_raddr = AW'(1);
      end
      OP_OUT_RD: begin
        ram_raddr = k_q;
      end
      OP_OUT_CAP: begin
        out_data_d  = ram_rdata;
        out_last_d  = last_k;
        out_ovf_d   = dropped_q;
        out_valid_d = 1'b1;
        k_d         = k_q + AW'(1);
        if (last_k) begin
          count_d   = '0;
          size_d    = '0;
          dropped_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      size_q      <= '0;
      dropped_q   <= 1'b0;
      p_q         <= '0;
      build_q     <= '0;
      k_q         <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      size_q      <= size_d;
      dropped_q   <= dropped_d;
      p_q         <= p_d;
      build_q     <= build_d;
      k_q         <= k_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q        <= v_d;
    l_q        <= l_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tlast_o    = out_last_q;
  assign m_axis_tuser_o[0] = out_ovf_q;

`ifndef SYNTHESIS
  a_cap_into_free_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_OUT_CAP) |-> (!out_valid_q || m_axis_tready_i))
    else $error("output register overwritten while an item is pending");

  a_sort_write_in_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && op_i != OP_LOAD) |-> (CW'(ram_waddr) < count_q))
    else $error("sort wrote outside the stored batch");

  a_heap_within_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= count_q)
    else $error("heap size exceeds the number of stored items");

  a_batch_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_OUT_CAP && last_k) |=> (count_q == '0 && !dropped_q))
    else $error("batch state not cleared after the last item");
`endif

endmodule
`default_nettype wire

// File: rtl/hse_controller.sv
// Sequencing state machine of the heap sort engine.
`default_nettype none
module hse_controller (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic              s_axis_tlast_i,
  input  wire hse_pkg::status_t  status_i,
  output hse_pkg::dp_op_e        op_o
);
  import hse_pkg::*;

  localparam logic [3:0] ST_LOAD      = 4'd0;
  localparam logic [3:0] ST_INIT      = 4'd1;
  localparam logic [3:0] ST_RD_NODE   = 4'd2;
  localparam logic [3:0] ST_LD_NODE   = 4'd3;
  localparam logic [3:0] ST_RD_RIGHT  = 4'd4;
  localparam logic [3:0] ST_CMP       = 4'd5;
  localparam logic [3:0] ST_FIN       = 4'd6;
  localparam logic [3:0] ST_SIFT_DONE = 4'd7;
  localparam logic [3:0] ST_X_CHK     = 4'd8;
  localparam logic [3:0] ST_X_RD_ROOT = 4'd9;
  localparam logic [3:0] ST_X_RD_LAST = 4'd10;
  localparam logic [3:0] ST_X_SWAP    = 4'd11;
  localparam logic [3:0] ST_OUT_RD    = 4'd12;
  localparam logic [3:0] ST_OUT_CAP   = 4'd13;

  logic [3:0] state_q, state_d;
  logic       building_q, building_d;

  assign s_axis_tready_o = (state_q == ST_LOAD);

  always_comb begin
    state_d    = state_q;
    building_d = building_q;
    op_o       = OP_IDLE;
    unique case (state_q)
      ST_LOAD: begin
        if (s_axis_tvalid_i) begin
          op_o = OP_LOAD;
          if (s_axis_tlast_i) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        op_o       = OP_INIT;
        building_d = 1'b1;
        state_d    = ST_RD_NODE;
      end
      ST_RD_NODE: begin
        op_o    = OP_RD_NODE;
        state_d = ST_LD_NODE;
      end
      ST_LD_NODE: begin
        op_o    = OP_LD_NODE;
        state_d = status_i.left_ok ? ST_RD_RIGHT : ST_SIFT_DONE;
      end
      ST_RD_RIGHT: begin
        op_o    = OP_RD_RIGHT;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        op_o = OP_CMP;
        if (status_i.cmp_move) begin
          state_d = status_i.next_left_ok ? ST_RD_RIGHT : ST_FIN;
        end else begin
          state_d = ST_SIFT_DONE;
        end
      end
      ST_FIN: begin
        op_o    = OP_FIN;
        state_d = ST_SIFT_DONE;
      end
      ST_SIFT_DONE: begin
        if (building_q && !status_i.build_zero) begin
          op_o    = OP_NEXT_BUILD;
          state_d = ST_RD_NODE;
        end else begin
          building_d = 1'b0;
          state_d    = ST_X_CHK;
        end
      end
      ST_X_CHK: begin
        state_d = status_i.size_gt1 ? ST_X_RD_ROOT : ST_OUT_RD;
      end
      ST_X_RD_ROOT: begin
        op_o    = OP_X_RD_ROOT;
        state_d = ST_X_RD_LAST;
      end
      ST_X_RD_LAST: begin
        op_o    = OP_X_RD_LAST;
        state_d = ST_X_SWAP;
      end
      ST_X_SWAP: begin
        op_o    = OP_X_SWAP;
        state_d = status_i.x_left_ok ? ST_RD_RIGHT : ST_FIN;
      end
      ST_OUT_RD: begin
        if (status_i.out_free) begin
          op_o    = OP_OUT_RD;
          state_d = ST_OUT_CAP;
        end
      end
      ST_OUT_CAP: begin
        op_o    = OP_OUT_CAP;
        state_d = status_i.out_last ? ST_LOAD : ST_OUT_RD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      building_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      building_q <= building_d;
    end
  end

`ifndef SYNTHESIS
  a_load_only_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_o == OP_LOAD) |-> (s_axis_tready_o && s_axis_tvalid_i))
    else $error("item stored without a completed handshake");

  a_build_ends_in_extract: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(building_q) |-> (state_q == ST_X_CHK))
    else $error("heap build left without entering extraction");

  a_no_build_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> !building_q)
    else $error("build flag still set while loading");
`endif

endmodule
`default_nettype wire

// File: rtl/heap_sort_engine_top.sv
// Top level of the heap sort engine: controller plus datapath.
//
// Usage: signed 64-bit values enter on the s_axis channel, one per item. The
// item with s_axis_tlast_i high closes the batch. Up to STORE_DEPTH values are
// kept; later items of the batch are dropped and every result of the batch
// then has m_axis_tuser_o[0] set. A dropped item still closes the batch.
// Loading takes one item per cycle. After the closing item the block stops
// accepting, builds a max-heap in the value store and extracts it, then reads
// the store out in ascending order on m_axis, the final item with tlast.
// Each sift level reads the right child, then compares and writes back, over the
// single read port of the store; each result is read from the store and then
// captured in the output register before the next one is read. The output
// register holds a result while the receiver stalls and the read-out waits for
// it. Loading of the next batch starts once the last result sits in the output
// register. Reset empties the batch, drops any pending result and returns to
// loading; the store needs no clearing.
`default_nettype none
module heap_sort_engine_top #(
  parameter int STORE_DEPTH = hse_pkg::DEFAULT_STORE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // [63:0] item_value
  input  wire logic        s_axis_tlast_i,   // batch_end
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [63:0] m_axis_tdata_o,   // [63:0] sorted_value
  output logic             m_axis_tlast_o,   // sorted_last
  output logic      [0:0]  m_axis_tuser_o    // [0] overflow
);
  import hse_pkg::*;

  dp_op_e  op;
  status_t status;

  hse_controller u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .status_i        (status),
    .op_o            (op)
  );

  hse_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .status_o        (status),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule
`default_nettype wire

// File: tb/heap_sort_checker.sv
// Checker for the heap sort engine: predicts sorted batches and compares results.
`timescale 1ns / 1ps
module heap_sort_checker #(
  parameter int STORE_DEPTH = hse_pkg::DEFAULT_STORE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [63:0] s_axis_tdata_i,   // [63:0] item_value
  input  wire logic        s_axis_tlast_i,   // batch_end
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [63:0] m_axis_tdata_i,   // [63:0] sorted_value
  input  wire logic        m_axis_tlast_i,   // sorted_last
  input  wire logic [0:0]  m_axis_tuser_i,   // [0] overflow
  output int               pending_o,
  output int               errors_o
);

  typedef struct packed {
    logic signed [63:0] value;
    logic               last;
    logic               overflow;
  } sorted_item_t;

  logic signed [63:0] batch_vals [STORE_DEPTH];
  int                 batch_count;
  logic               batch_dropped;
  sorted_item_t       sorted_q[$];
  int                 err_count;

  // Iterative max-heap sift-down over the first heap_size entries.
  function automatic void sift_down(input int start, input int heap_size);
    int                 node;
    int                 child;
    int                 top;
    logic signed [63:0] tmp;
    node = start;
    while (1) begin
      top   = node;
      child = 2 * node + 1;
      if (child < heap_size && batch_vals[child] > batch_vals[top]) top = child;
      if (child + 1 < heap_size && batch_vals[child + 1] > batch_vals[top]) top = child + 1;
      if (top == node) break;
      tmp              = batch_vals[top];
      batch_vals[top]  = batch_vals[node];
      batch_vals[node] = tmp;
      node             = top;
    end
  endfunction

  function automatic void sort_batch(input int n);
    logic signed [63:0] tmp;
    for (int i = n / 2; i >= 0; i--) sift_down(i, n);
    for (int i = n - 1; i > 0; i--) begin
      tmp           = batch_vals[0];
      batch_vals[0] = batch_vals[i];
      batch_vals[i] = tmp;
      sift_down(0, i);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_item_t got;
    sorted_item_t want;
    if (!rst_ni) begin
      batch_count   = 0;
      batch_dropped = 1'b0;
      err_count     = 0;
      sorted_q.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.value    = m_axis_tdata_i;
        got.last     = m_axis_tlast_i;
        got.overflow = m_axis_tuser_i[0];
        if (sorted_q.size() == 0) begin
          $error("unexpected result: sorted_value %h last %b overflow %b",
                 got.value, got.last, got.overflow);
          err_count++;
        end else begin
          want = sorted_q.pop_front();
          if (got.value !== want.value) begin
            $error("sorted_value: expected %h, actual %h", want.value, got.value);
            err_count++;
          end
          if (got.last !== want.last) begin
            $error("sorted_last: expected %b, actual %b", want.last, got.last);
            err_count++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow: expected %b, actual %b", want.overflow, got.overflow);
            err_count++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (batch_count < STORE_DEPTH) begin
          batch_vals[batch_count] = s_axis_tdata_i;
          batch_count++;
        end else begin
          batch_dropped = 1'b1;
        end
        if (s_axis_tlast_i) begin
          sort_batch(batch_count);
          for (int k = 0; k < batch_count; k++) begin
            want.value    = batch_vals[k];
            want.last     = (k == batch_count - 1);
            want.overflow = batch_dropped;
            sorted_q.insert(sorted_q.size(), want);
          end
          batch_count   = 0;
          batch_dropped = 1'b0;
        end
      end
      pending_o <= sorted_q.size();
      errors_o  <= err_count;
    end
  end

endmodule

// File: tb/tb_heap_sort_engine_top.sv
// Testbench top of the heap sort engine: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps
module tb_heap_sort_engine_top;

  localparam int STORE_DEPTH = hse_pkg::DEFAULT_STORE_DEPTH;
  localparam int NUM_ITEMS   = 450;
  localparam int TAIL_ITEMS  = 40;
  localparam int IDLE_LIMIT  = 8000;
  localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] VAL_MAX = 64'h7fff_ffff_ffff_ffff;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [63:0] s_data  = '0;
  logic        s_last  = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [63:0] m_data;
  logic        m_last;
  logic [0:0]  m_user;

  int pending;
  int errors;
  int items_sent     = 0;
  int batches_sent   = 0;
  int overrun_sent   = 0;
  int idle_cycles    = 0;
  int stall_left     = 0;
  logic quiet        = 1'b0;

  heap_sort_engine_top #(.STORE_DEPTH(STORE_DEPTH)) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  heap_sort_checker #(.STORE_DEPTH(STORE_DEPTH)) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tlast_i  (m_last),
    .m_axis_tuser_i  (m_user),
    .pending_o       (pending),
    .errors_o        (errors)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver stalls in random bursts unless the run is in a quiet stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      m_ready    <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      m_ready    <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_ready    <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_ready    <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return 64'($signed($urandom_range(0, 8)) - 4);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_item(input logic [63:0] value, input logic batch_end);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= value;
    s_last  <= batch_end;
    do @(posedge clk); while (!s_ready);
    items_sent++;
    if (batch_end) batches_sent++;
  endtask

  // Holds the sender off until every predicted result has left the block.
  task automatic drain_results();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random_batch(input int n);
    for (int i = 0; i < n; i++) send_item(pick_value(), i == n - 1);
    if (n > STORE_DEPTH) overrun_sent++;
  endtask

  initial begin
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-value batches at both extremes, then small ordered and tied sets.
    send_item(VAL_MIN, 1'b1);
    send_item(VAL_MAX, 1'b1);
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b1);
    send_item(VAL_MAX, 1'b0);
    send_item(64'd1, 1'b0);
    send_item(64'd0, 1'b0);
    send_item(-64'sd1, 1'b0);
    send_item(VAL_MIN, 1'b1);
    send_item(64'd5, 1'b0);
    send_item(64'd5, 1'b0);
    send_item(64'd5, 1'b1);
    send_item(VAL_MIN, 1'b0);
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b0);
    send_item(VAL_MAX, 1'b1);
    send_item(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    send_item(64'h5555_5555_5555_5555, 1'b0);
    send_item(64'd0, 1'b1);
    drain_results();

    // A store filled exactly, then one overrun where the closing item is dropped.
    send_random_batch(STORE_DEPTH);
    send_random_batch(STORE_DEPTH + 3);

    while (items_sent < NUM_ITEMS) begin
      if (items_sent >= NUM_ITEMS - TAIL_ITEMS) quiet = 1'b1;
      else quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 11) == 0) n = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 6);
      else n = $urandom_range(1, 12);
      send_random_batch(n);
      if ($urandom_range(0, 5) == 0) drain_results();
    end

    quiet = 1'b1;
    drain_results();
    repeat (200) @(posedge clk);

    $display("Sorted %0d batches built from %0d items; %0d batches overran the store.",
             batches_sent, items_sent, overrun_sent);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: heap_sort_engine_top.f
rtl/hse_pkg.sv
rtl/hse_ram.sv
rtl/hse_datapath.sv
rtl/hse_controller.sv
rtl/heap_sort_engine_top.sv
tb/heap_sort_checker.sv
tb/tb_heap_sort_engine_top.sv
